/* hdl/bps_pkg.sv */
// ----------------------------------------------------------------------------
// bps_pkg: shared types and constants for the Blinn-Phong pixel shader
// Component formats, transaction payloads, register indexes and saturation.
// ----------------------------------------------------------------------------
package bps_pkg;

    localparam int CW       = 20;          // signed Q7.12 component width
    localparam int UW       = 14;          // unit vector component, -4096..4096
    localparam int FW       = 13;          // clamped dot product, 0..4096
    localparam int REG_W    = 3 * CW;      // packed vector register width
    localparam int SQ_N     = CW + 8;      // root bits of (sum of squares << 16)
    localparam int QB       = 13;          // quotient bits of one normalized component
    localparam int NORM_LAT = 3 + SQ_N + 1 + QB + 1;
    localparam int POW_STEPS = 6;          // exponent 64 as six squarings
    localparam int QDEPTH   = 4;           // queue depth, power of two
    localparam int ONE_Q12  = 4096;
    localparam int SAT_W    = 64;

    typedef logic signed [CW-1:0] comp_t;
    typedef logic signed [UW-1:0] unit_t;
    typedef logic        [FW-1:0] frac_t;
    typedef comp_t vec_t  [3];
    typedef unit_t uvec_t [3];
    typedef frac_t fvec_t [3];

    localparam comp_t AMBIENT = comp_t'(410);

    localparam logic [REG_W-1:0] LIGHT_COLOR_RESET =
        {comp_t'(ONE_Q12), comp_t'(ONE_Q12), comp_t'(ONE_Q12)};
    localparam logic [REG_W-1:0] LIGHT_DIR_RESET =
        {comp_t'(0), comp_t'(0), comp_t'(-ONE_Q12)};
    localparam logic [REG_W-1:0] CAMERA_POS_RESET = '0;

    typedef logic [1:0] cfg_addr_t;
    localparam cfg_addr_t ADDR_LIGHT_COLOR = 2'd0;
    localparam cfg_addr_t ADDR_LIGHT_DIR   = 2'd1;
    localparam cfg_addr_t ADDR_CAMERA_POS  = 2'd2;
    localparam cfg_addr_t ADDR_VIEW_MODE   = 2'd3;

    typedef logic [2:0] mode_t;
    localparam mode_t MODE_SHADED   = 3'd0;
    localparam mode_t MODE_BASE     = 3'd1;
    localparam mode_t MODE_NORMAL   = 3'd2;
    localparam mode_t MODE_POSITION = 3'd3;
    localparam mode_t MODE_AMBIENT  = 3'd4;
    localparam mode_t MODE_DIFFUSE  = 3'd5;
    localparam mode_t MODE_SPECULAR = 3'd6;

    typedef struct packed {
        comp_t surface_normal_x;
        comp_t surface_normal_y;
        comp_t surface_normal_z;
        comp_t world_pos_x;
        comp_t world_pos_y;
        comp_t world_pos_z;
        frac_t base_red;
        frac_t base_green;
        frac_t base_blue;
    } in_item_t;

    typedef struct packed {
        comp_t out_red;
        comp_t out_green;
        comp_t out_blue;
    } out_item_t;

    typedef struct {
        vec_t  light;
        vec_t  dir;
        vec_t  cam;
        mode_t mode;
    } cfg_t;

    // one queued pixel: raw vectors ready for normalization
    typedef struct {
        vec_t  nraw;
        vec_t  lraw;
        vec_t  vraw;
        vec_t  pos;
        fvec_t base;
    } work_t;

    localparam logic signed [SAT_W-1:0] SAT_HI = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - 64'sd1;

    function automatic comp_t sat_comp(input logic signed [SAT_W-1:0] v);
        if (v > SAT_HI) begin
            return comp_t'(SAT_HI);
        end else if (v < SAT_LO) begin
            return comp_t'(SAT_LO);
        end
        return comp_t'(v);
    endfunction

endpackage

/* hdl/bps_front.sv */
// ----------------------------------------------------------------------------
// bps_front: input stage
// Accepts pixels, forms the raw light and view vectors and feeds the queue.
// ----------------------------------------------------------------------------
module bps_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bps_pkg::in_item_t s_data,
    input  bps_pkg::cfg_t     cfg,
    output logic              q_valid,
    input  logic              q_ready,
    output bps_pkg::work_t    q_data
);

    logic           vld_reg;
    logic           vld_next;
    bps_pkg::work_t data_reg;
    bps_pkg::work_t data_next;
    logic           accept;
    logic           push;
    bps_pkg::vec_t  pos;

    assign s_ready = !vld_reg || q_ready;
    assign accept  = s_valid && s_ready;
    assign push    = vld_reg && q_ready;
    assign q_valid = vld_reg;
    assign q_data  = data_reg;

    always_comb begin
        pos[0] = s_data.world_pos_x;
        pos[1] = s_data.world_pos_y;
        pos[2] = s_data.world_pos_z;
        data_next.nraw[0] = s_data.surface_normal_x;
        data_next.nraw[1] = s_data.surface_normal_y;
        data_next.nraw[2] = s_data.surface_normal_z;
        data_next.base[0] = s_data.base_red;
        data_next.base[1] = s_data.base_green;
        data_next.base[2] = s_data.base_blue;
        for (int i = 0; i < 3; i++) begin
            data_next.pos[i]  = pos[i];
            // light vector points toward the light
            data_next.lraw[i] = bps_pkg::sat_comp(-(64'(cfg.dir[i])));
            data_next.vraw[i] = bps_pkg::sat_comp(64'(cfg.cam[i]) - 64'(pos[i]));
        end
    end

    always_comb begin
        if (accept) begin
            vld_next = 1'b1;
        end else if (push) begin
            vld_next = 1'b0;
        end else begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= data_next;
        end
    end

endmodule

/* hdl/bps_fifo.sv */
// ----------------------------------------------------------------------------
// bps_fifo: pixel queue
// Small register queue that decouples the input stage from the shading pipe.
// ----------------------------------------------------------------------------
module bps_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  bps_pkg::work_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output bps_pkg::work_t pop_data
);

    localparam int DEPTH = bps_pkg::QDEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    bps_pkg::work_t  mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CNTW-1:0] count_reg;
    logic            push;
    logic            pop;

    assign push_ready = count_reg != CNTW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNTW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNTW'(1);
            end
        end
    end

endmodule

/* hdl/bps_norm.sv */
// ----------------------------------------------------------------------------
// bps_norm: pipelined vector normalizer
// Sum of squares, one root bit per stage, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bps_norm (
    input  logic           aclk,
    input  logic           en,
    input  bps_pkg::vec_t  in_vec,
    output bps_pkg::uvec_t out_vec
);

    localparam int CW   = bps_pkg::CW;
    localparam int SQ_N = bps_pkg::SQ_N;
    localparam int QB   = bps_pkg::QB;
    localparam int RW   = SQ_N + 2;
    localparam int NW   = CW + 21;

    typedef logic [CW-1:0] mag_t;

    typedef struct {
        logic [2*SQ_N-1:0] rad;
        logic [SQ_N-1:0]   root;
        logic [RW-1:0]     rem;
        mag_t              mag [3];
        logic              neg [3];
        logic              zero;
    } sq_st_t;

    typedef struct {
        logic [NW-1:0] num [3];
        logic [SQ_N:0] den;
        logic [QB-1:0] q   [3];
        logic          neg [3];
        logic          zero;
    } dv_st_t;

    function automatic sq_st_t sqrt_step(input sq_st_t s);
        sq_st_t        r;
        logic [RW+1:0] cur;
        logic [RW+1:0] trial;
        r     = s;
        cur   = {s.rem, s.rad[2*SQ_N-1 -: 2]};
        trial = {2'b00, s.root, 2'b01};
        if (cur >= trial) begin
            r.rem  = RW'(cur - trial);
            r.root = {s.root[SQ_N-2:0], 1'b1};
        end else begin
            r.rem  = RW'(cur);
            r.root = {s.root[SQ_N-2:0], 1'b0};
        end
        r.rad = {s.rad[2*SQ_N-3:0], 2'b00};
        return r;
    endfunction

    function automatic dv_st_t div_step(input dv_st_t s, input int k);
        dv_st_t      r;
        logic [NW:0] dsh;
        r   = s;
        dsh = (NW+1)'(s.den) << k;
        for (int i = 0; i < 3; i++) begin
            if ({1'b0, s.num[i]} >= dsh) begin
                r.num[i] = NW'({1'b0, s.num[i]} - dsh);
                r.q[i]   = {s.q[i][QB-2:0], 1'b1};
            end else begin
                r.q[i]   = {s.q[i][QB-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    mag_t              m0_reg  [3];
    logic              n0_reg  [3];
    logic [2*CW-1:0]   sq1_reg [3];
    mag_t              m1_reg  [3];
    logic              n1_reg  [3];
    logic [2*CW-1:0]   s2_reg;
    mag_t              m2_reg  [3];
    logic              n2_reg  [3];
    sq_st_t            sq_init;
    sq_st_t            sq_in   [SQ_N];
    sq_st_t            sq_reg  [SQ_N];
    dv_st_t            dv_in   [QB+1];
    dv_st_t            dv_reg  [QB+1];
    bps_pkg::uvec_t    o_next;
    bps_pkg::uvec_t    o_reg;
    logic [SQ_N-1:0]   len;

    assign out_vec = o_reg;

    always_comb begin
        sq_init.rad  = {s2_reg, 16'b0};
        sq_init.root = '0;
        sq_init.rem  = '0;
        sq_init.zero = s2_reg == '0;
        for (int i = 0; i < 3; i++) begin
            sq_init.mag[i] = m2_reg[i];
            sq_init.neg[i] = n2_reg[i];
        end
        sq_in[0] = sqrt_step(sq_init);
        for (int k = 1; k < SQ_N; k++) begin
            sq_in[k] = sqrt_step(sq_reg[k-1]);
        end
    end

    // division entry: |c| * 2^21 + len over 2 * len
    always_comb begin
        len          = sq_reg[SQ_N-1].root;
        dv_in[0].den = {len, 1'b0};
        dv_in[0].zero = sq_reg[SQ_N-1].zero;
        for (int i = 0; i < 3; i++) begin
            dv_in[0].num[i] = (NW'(sq_reg[SQ_N-1].mag[i]) << 21) + NW'(len);
            dv_in[0].q[i]   = '0;
            dv_in[0].neg[i] = sq_reg[SQ_N-1].neg[i];
        end
        for (int j = 1; j <= QB; j++) begin
            dv_in[j] = div_step(dv_reg[j-1], QB - j);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (dv_reg[QB].zero) begin
                o_next[i] = '0;
            end else if (dv_reg[QB].neg[i]) begin
                o_next[i] = -bps_pkg::unit_t'({1'b0, dv_reg[QB].q[i]});
            end else begin
                o_next[i] = bps_pkg::unit_t'({1'b0, dv_reg[QB].q[i]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                n0_reg[i]  <= in_vec[i][CW-1];
                m0_reg[i]  <= in_vec[i][CW-1] ? mag_t'(-in_vec[i]) : mag_t'(in_vec[i]);
                sq1_reg[i] <= (2*CW)'(m0_reg[i]) * (2*CW)'(m0_reg[i]);
                m1_reg[i]  <= m0_reg[i];
                n1_reg[i]  <= n0_reg[i];
                m2_reg[i]  <= m1_reg[i];
                n2_reg[i]  <= n1_reg[i];
            end
            s2_reg <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
            for (int k = 0; k < SQ_N; k++) begin
                sq_reg[k] <= sq_in[k];
            end
            for (int j = 0; j <= QB; j++) begin
                dv_reg[j] <= dv_in[j];
            end
            o_reg <= o_next;
        end
    end

endmodule

/* hdl/bps_back.sv */
// ----------------------------------------------------------------------------
// bps_back: shading pipeline
// Normalizes N, L, V and H, forms diffuse and specular terms, picks the view.
// ----------------------------------------------------------------------------
module bps_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  bps_pkg::work_t     q_data,
    input  bps_pkg::cfg_t      cfg,
    output logic               m_valid,
    input  logic               m_ready,
    output bps_pkg::out_item_t m_data
);

    localparam int CW    = bps_pkg::CW;
    localparam int UW    = bps_pkg::UW;
    localparam int FW    = bps_pkg::FW;
    localparam int NL    = bps_pkg::NORM_LAT;
    localparam int NPW   = bps_pkg::POW_STEPS;
    localparam int BL    = 2 * NL + NPW + 6;
    localparam int PW    = 2 * UW;
    localparam int DW    = PW + 2;
    localparam int LCB_W = CW + FW + 1;
    localparam int DR_W  = LCB_W + FW + 1;
    localparam int SR_W  = CW + FW + 1;

    typedef logic signed [PW-1:0]    prod_t;
    typedef prod_t                   prod_vec_t [3];
    typedef logic signed [LCB_W-1:0] lcb_t;
    typedef lcb_t                    lcb_vec_t [3];
    typedef logic signed [DR_W-1:0]  dr_t;
    typedef logic signed [SR_W-1:0]  sr_t;

    function automatic bps_pkg::frac_t dot_clamp(input prod_vec_t p);
        logic signed [DW-1:0] d;
        logic signed [DW-1:0] r;
        d = DW'(p[0]) + DW'(p[1]) + DW'(p[2]);
        if (d <= 0) begin
            return '0;
        end
        r = (d + DW'(2048)) >>> 12;
        if (r > DW'(bps_pkg::ONE_Q12)) begin
            return FW'(bps_pkg::ONE_Q12);
        end
        return FW'(r);
    endfunction

    function automatic bps_pkg::frac_t pow_step(input bps_pkg::frac_t p);
        logic [2*FW:0] sq;
        sq = (2*FW+1)'(p) * (2*FW+1)'(p) + (2*FW+1)'(2048);
        return FW'(sq >> 12);
    endfunction

    // rounds half away from zero
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int sh);
        logic [63:0] m;
        logic [63:0] r;
        m = v[63] ? 64'(-v) : 64'(v);
        r = (m + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

    logic               en;
    logic [BL-1:0]      vld_reg;
    bps_pkg::uvec_t     n_a;
    bps_pkg::uvec_t     l_a;
    bps_pkg::uvec_t     v_a;
    bps_pkg::uvec_t     h_b;
    bps_pkg::vec_t      pa_reg [NL];
    bps_pkg::fvec_t     ba_reg [NL];
    bps_pkg::vec_t      h0_t_reg;
    bps_pkg::uvec_t     h0_n_reg;
    bps_pkg::uvec_t     h0_l_reg;
    bps_pkg::vec_t      h0_pos_reg;
    bps_pkg::fvec_t     h0_base_reg;
    bps_pkg::uvec_t     nb_reg [NL];
    bps_pkg::uvec_t     lb_reg [NL];
    bps_pkg::vec_t      pb_reg [NL];
    bps_pkg::fvec_t     bb_reg [NL];
    prod_vec_t          nl_reg;
    prod_vec_t          nh_reg;
    lcb_vec_t           lcb_reg;
    bps_pkg::uvec_t     d0_n_reg;
    bps_pkg::vec_t      d0_pos_reg;
    bps_pkg::fvec_t     d0_base_reg;
    bps_pkg::frac_t     ndl_reg;
    bps_pkg::frac_t     ndh_reg;
    lcb_vec_t           d1_lcb_reg;
    bps_pkg::uvec_t     d1_n_reg;
    bps_pkg::vec_t      d1_pos_reg;
    bps_pkg::fvec_t     d1_base_reg;
    bps_pkg::frac_t     pw_p_reg    [NPW];
    bps_pkg::uvec_t     pw_n_reg    [NPW];
    bps_pkg::vec_t      pw_pos_reg  [NPW];
    bps_pkg::fvec_t     pw_base_reg [NPW];
    dr_t                draw_reg    [3];
    bps_pkg::vec_t      diff_reg    [NPW-1];
    sr_t                sraw_reg    [3];
    bps_pkg::vec_t      s0_diff_reg;
    bps_pkg::uvec_t     s0_n_reg;
    bps_pkg::vec_t      s0_pos_reg;
    bps_pkg::fvec_t     s0_base_reg;
    bps_pkg::vec_t      spec_reg;
    bps_pkg::vec_t      s1_diff_reg;
    bps_pkg::uvec_t     s1_n_reg;
    bps_pkg::vec_t      s1_pos_reg;
    bps_pkg::fvec_t     s1_base_reg;
    bps_pkg::vec_t      disp;
    bps_pkg::out_item_t out_reg;

    assign en      = !vld_reg[BL-1] || m_ready;
    assign q_ready = en;
    assign m_valid = vld_reg[BL-1];
    assign m_data  = out_reg;

    bps_norm u_norm_n (.aclk(aclk), .en(en), .in_vec(q_data.nraw), .out_vec(n_a));
    bps_norm u_norm_l (.aclk(aclk), .en(en), .in_vec(q_data.lraw), .out_vec(l_a));
    bps_norm u_norm_v (.aclk(aclk), .en(en), .in_vec(q_data.vraw), .out_vec(v_a));
    bps_norm u_norm_h (.aclk(aclk), .en(en), .in_vec(h0_t_reg),    .out_vec(h_b));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[BL-2:0], q_valid};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            unique case (cfg.mode)
                bps_pkg::MODE_BASE:     disp[i] = bps_pkg::comp_t'({1'b0, s1_base_reg[i]});
                bps_pkg::MODE_NORMAL:   disp[i] = bps_pkg::comp_t'(s1_n_reg[i]);
                bps_pkg::MODE_POSITION: disp[i] = s1_pos_reg[i];
                bps_pkg::MODE_AMBIENT:  disp[i] = bps_pkg::AMBIENT;
                bps_pkg::MODE_DIFFUSE:  disp[i] = s1_diff_reg[i];
                bps_pkg::MODE_SPECULAR: disp[i] = spec_reg[i];
                default: begin
                    disp[i] = bps_pkg::sat_comp(64'(bps_pkg::AMBIENT) + 64'(s1_diff_reg[i])
                                                + 64'(spec_reg[i]));
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // first normalizer set runs alongside the position and base delay
            pa_reg[0] <= q_data.pos;
            ba_reg[0] <= q_data.base;
            for (int k = 1; k < NL; k++) begin
                pa_reg[k] <= pa_reg[k-1];
                ba_reg[k] <= ba_reg[k-1];
            end

            for (int i = 0; i < 3; i++) begin
                h0_t_reg[i] <= bps_pkg::comp_t'(v_a[i]) + bps_pkg::comp_t'(l_a[i]);
            end
            h0_n_reg    <= n_a;
            h0_l_reg    <= l_a;
            h0_pos_reg  <= pa_reg[NL-1];
            h0_base_reg <= ba_reg[NL-1];

            nb_reg[0] <= h0_n_reg;
            lb_reg[0] <= h0_l_reg;
            pb_reg[0] <= h0_pos_reg;
            bb_reg[0] <= h0_base_reg;
            for (int k = 1; k < NL; k++) begin
                nb_reg[k] <= nb_reg[k-1];
                lb_reg[k] <= lb_reg[k-1];
                pb_reg[k] <= pb_reg[k-1];
                bb_reg[k] <= bb_reg[k-1];
            end

            for (int i = 0; i < 3; i++) begin
                nl_reg[i]  <= PW'(lb_reg[NL-1][i]) * PW'(nb_reg[NL-1][i]);
                nh_reg[i]  <= PW'(nb_reg[NL-1][i]) * PW'(h_b[i]);
                lcb_reg[i] <= LCB_W'(cfg.light[i]) * LCB_W'($signed({1'b0, bb_reg[NL-1][i]}));
            end
            d0_n_reg    <= nb_reg[NL-1];
            d0_pos_reg  <= pb_reg[NL-1];
            d0_base_reg <= bb_reg[NL-1];

            ndl_reg     <= dot_clamp(nl_reg);
            ndh_reg     <= dot_clamp(nh_reg);
            d1_lcb_reg  <= lcb_reg;
            d1_n_reg    <= d0_n_reg;
            d1_pos_reg  <= d0_pos_reg;
            d1_base_reg <= d0_base_reg;

            pw_p_reg[0]    <= pow_step(ndh_reg);
            pw_n_reg[0]    <= d1_n_reg;
            pw_pos_reg[0]  <= d1_pos_reg;
            pw_base_reg[0] <= d1_base_reg;
            for (int i = 0; i < 3; i++) begin
                draw_reg[i]    <= DR_W'(d1_lcb_reg[i]) * DR_W'($signed({1'b0, ndl_reg}));
                diff_reg[0][i] <= bps_pkg::sat_comp(round_shift(64'(draw_reg[i]), 24));
            end
            for (int j = 1; j < NPW; j++) begin
                pw_p_reg[j]    <= pow_step(pw_p_reg[j-1]);
                pw_n_reg[j]    <= pw_n_reg[j-1];
                pw_pos_reg[j]  <= pw_pos_reg[j-1];
                pw_base_reg[j] <= pw_base_reg[j-1];
            end
            for (int j = 1; j < NPW - 1; j++) begin
                diff_reg[j] <= diff_reg[j-1];
            end

            for (int i = 0; i < 3; i++) begin
                sraw_reg[i] <= SR_W'(cfg.light[i]) * SR_W'($signed({1'b0, pw_p_reg[NPW-1]}));
                spec_reg[i] <= bps_pkg::sat_comp(round_shift(64'(sraw_reg[i]), 12));
            end
            s0_diff_reg <= diff_reg[NPW-2];
            s0_n_reg    <= pw_n_reg[NPW-1];
            s0_pos_reg  <= pw_pos_reg[NPW-1];
            s0_base_reg <= pw_base_reg[NPW-1];

            s1_diff_reg <= s0_diff_reg;
            s1_n_reg    <= s0_n_reg;
            s1_pos_reg  <= s0_pos_reg;
            s1_base_reg <= s0_base_reg;

            out_reg.out_red   <= disp[0];
            out_reg.out_green <= disp[1];
            out_reg.out_blue  <= disp[2];
        end
    end

endmodule

/* hdl/blinn_phong_pixel_shading.sv */
// ----------------------------------------------------------------------------
// blinn_phong_pixel_shading: fixed-point Blinn-Phong pixel shader
// Normalizes N, L, V, H and returns the shaded color or a debug view.
//
//   channel | handshake               | payload
//   --------+-------------------------+---------------------------
//   s_      | s_valid / s_ready       | in_item_t  (normal, pos, base)
//   m_      | m_valid / m_ready       | out_item_t (red, green, blue)
//   cfg_    | cfg_wr_en, no wait      | cfg_addr, cfg_wdata (60 bits)
//
// One pixel per cycle while the output does not stall; pipeline depth is
// set mostly by two normalizers in series (28 root stages plus 13 quotient stages each).
// Synchronous active-low reset clears the valid pipeline, queue and registers.
// Output stall freezes the shading pipe; the 4-entry queue and the input
// register absorb transactions before s_ready drops.
// ----------------------------------------------------------------------------
module blinn_phong_pixel_shading (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bps_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bps_pkg::out_item_t            m_data,
    input  logic                          cfg_wr_en,
    input  bps_pkg::cfg_addr_t            cfg_addr,
    input  logic [bps_pkg::REG_W-1:0]     cfg_wdata
);

    localparam int CW = bps_pkg::CW;

    logic [bps_pkg::REG_W-1:0] light_color_reg;
    logic [bps_pkg::REG_W-1:0] light_dir_reg;
    logic [bps_pkg::REG_W-1:0] camera_pos_reg;
    bps_pkg::mode_t            view_mode_reg;
    bps_pkg::cfg_t             cfg;
    logic                      q_push_valid;
    logic                      q_push_ready;
    bps_pkg::work_t            q_push_data;
    logic                      q_pop_valid;
    logic                      q_pop_ready;
    bps_pkg::work_t            q_pop_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_color_reg <= bps_pkg::LIGHT_COLOR_RESET;
            light_dir_reg   <= bps_pkg::LIGHT_DIR_RESET;
            camera_pos_reg  <= bps_pkg::CAMERA_POS_RESET;
            view_mode_reg   <= bps_pkg::MODE_SHADED;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                bps_pkg::ADDR_LIGHT_COLOR: light_color_reg <= cfg_wdata;
                bps_pkg::ADDR_LIGHT_DIR:   light_dir_reg   <= cfg_wdata;
                bps_pkg::ADDR_CAMERA_POS:  camera_pos_reg  <= cfg_wdata;
                bps_pkg::ADDR_VIEW_MODE:   view_mode_reg   <= cfg_wdata[2:0];
                default:                   view_mode_reg   <= view_mode_reg;
            endcase
        end
    end

    // x / red in the top field
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cfg.light[i] = bps_pkg::comp_t'(light_color_reg[(3 - i) * CW - 1 -: CW]);
            cfg.dir[i]   = bps_pkg::comp_t'(light_dir_reg[(3 - i) * CW - 1 -: CW]);
            cfg.cam[i]   = bps_pkg::comp_t'(camera_pos_reg[(3 - i) * CW - 1 -: CW]);
        end
        cfg.mode = view_mode_reg;
    end

    bps_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg),
        .q_valid (q_push_valid),
        .q_ready (q_push_ready),
        .q_data  (q_push_data)
    );

    bps_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    bps_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_pop_valid),
        .q_ready (q_pop_ready),
        .q_data  (q_pop_data),
        .cfg     (cfg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
